[src/ntm_pkg.sv]
// ----------------------------------------------------------------------------
// ntm_pkg
// Shared widths, opcodes, controller states and the command and status
// bundles of the nearest timestamp matcher.
// ----------------------------------------------------------------------------
package ntm_pkg;

  localparam int REF_DEPTH_DEF = 4096;
  localparam int STAMP_W       = 63;
  localparam int OP_W          = 2;
  localparam int IDX_W         = 12;
  localparam int CFG_W         = 32;

  localparam logic [CFG_W-1:0] DIFF_LIMIT_RESET = 32'd10000000;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic check;
    logic walk;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic query_go;
    logic below_first;
    logic grow;
    logic at_end;
    logic out_free;
  } sts_t;

endpackage

[src/ntm_req_if.sv]
// ----------------------------------------------------------------------------
// ntm_req_if
// Input item channel: opcode and timestamp with valid and ready.
// ----------------------------------------------------------------------------
interface ntm_req_if;
  logic                         valid;
  logic                         ready;
  logic [ntm_pkg::OP_W-1:0]     opcode;
  logic [ntm_pkg::STAMP_W-1:0]  stamp;

  modport source (output valid, output opcode, output stamp, input ready);
  modport sink (input valid, input opcode, input stamp, output ready);
endinterface

[src/ntm_rsp_if.sv]
// ----------------------------------------------------------------------------
// ntm_rsp_if
// Result item channel: match flags and index with valid and ready.
// ----------------------------------------------------------------------------
interface ntm_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       matched;
  logic [ntm_pkg::IDX_W-1:0]  match_index;
  logic                       too_far;
  logic                       list_full;

  modport source (output valid, output matched, output match_index, output too_far,
                  output list_full, input ready);
  modport sink (input valid, input matched, input match_index, input too_far,
                input list_full, output ready);
endinterface

[src/ntm_cfg_if.sv]
// ----------------------------------------------------------------------------
// ntm_cfg_if
// Configuration write channel for the distance limit register.
// ----------------------------------------------------------------------------
interface ntm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ntm_pkg::CFG_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/ntm_ctrl.sv]
// ----------------------------------------------------------------------------
// ntm_ctrl
// Sequencer: accept an item, for a query check the first entry and walk the
// list, hand the result to the output register.
// ----------------------------------------------------------------------------
module ntm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ntm_pkg::sts_t sts_i,
  output ntm_pkg::cmd_t cmd_o
);

  ntm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ntm_pkg::ST_IDLE: begin
        if (sts_i.in_valid) begin
          state_d = sts_i.query_go ? ntm_pkg::ST_CHECK : ntm_pkg::ST_DONE;
        end
      end
      ntm_pkg::ST_CHECK: begin
        state_d = sts_i.below_first ? ntm_pkg::ST_DONE : ntm_pkg::ST_WALK;
      end
      ntm_pkg::ST_WALK: begin
        if (sts_i.grow || sts_i.at_end) begin
          state_d = ntm_pkg::ST_DONE;
        end
      end
      ntm_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ntm_pkg::ST_IDLE;
        end
      end
      default: state_d = ntm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ntm_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.accept   = sts_i.in_valid;
      end
      ntm_pkg::ST_CHECK: cmd_o.check = 1'b1;
      ntm_pkg::ST_WALK:  cmd_o.walk  = 1'b1;
      ntm_pkg::ST_DONE:  cmd_o.load  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

[src/ntm_datapath.sv]
// ----------------------------------------------------------------------------
// ntm_datapath
// Reference store, walk registers, result register, output register and
// the distance limit register.
// ----------------------------------------------------------------------------
module ntm_datapath #(
  parameter int REF_DEPTH = ntm_pkg::REF_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ntm_req_if.sink        req_i,
  ntm_rsp_if.source      rsp_o,
  ntm_cfg_if.sink        cfg_i,
  input  ntm_pkg::cmd_t  cmd_i,
  output ntm_pkg::sts_t  sts_o
);

  localparam int AW = $clog2(REF_DEPTH);
  localparam int CW = $clog2(REF_DEPTH + 1);
  localparam int SW = ntm_pkg::STAMP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(REF_DEPTH);

  logic [SW-1:0] mem [REF_DEPTH];
  logic [SW-1:0] rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] prev_idx_q, prev_idx_d;
  logic          prev_hit_q, prev_hit_d;
  logic          out_valid_q, out_valid_d;
  logic [ntm_pkg::CFG_W-1:0] diff_limit_q;

  logic [SW-1:0] stamp_q, stamp_d;
  logic [AW-1:0] j_q, j_d;
  logic [SW-1:0] last_q, last_d;
  logic          res_matched_q, res_matched_d;
  logic [AW-1:0] res_idx_q, res_idx_d;
  logic [SW-1:0] res_dist_q, res_dist_d;
  logic          res_full_q, res_full_d;
  logic          out_matched_q, out_matched_d;
  logic [ntm_pkg::IDX_W-1:0] out_idx_q, out_idx_d;
  logic          out_far_q, out_far_d;
  logic          out_full_q, out_full_d;

  logic [SW:0]   diff_ab;
  logic [SW-1:0] cur_dist;
  logic [AW-1:0] j_pick, j_start;

  // distance of the entry under the walk to the query stamp
  assign diff_ab  = {1'b0, rd_data_q} - {1'b0, stamp_q};
  assign cur_dist = diff_ab[SW] ? (stamp_q - rd_data_q) : diff_ab[SW-1:0];

  assign j_pick  = prev_hit_q ? prev_idx_q : '0;
  assign j_start = (CW'(j_pick) >= count_q) ? '0 : j_pick;

  assign sts_o.in_valid    = req_i.valid;
  assign sts_o.query_go    = (req_i.opcode == ntm_pkg::OP_QUERY) && (count_q != '0);
  assign sts_o.below_first = stamp_q < rd_data_q;
  assign sts_o.grow        = cur_dist > last_q;
  assign sts_o.at_end      = CW'(j_q) == (count_q - CW'(1));
  assign sts_o.out_free    = !out_valid_q || rsp_o.ready;

  assign req_i.ready       = cmd_i.in_ready;
  assign cfg_i.ready       = 1'b1;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.matched     = out_matched_q;
  assign rsp_o.match_index = out_idx_q;
  assign rsp_o.too_far     = out_far_q;
  assign rsp_o.list_full   = out_full_q;

  assign mem_we = cmd_i.accept && (req_i.opcode == ntm_pkg::OP_APPEND) && (count_q < DEPTH_C);

  always_comb begin
    if (cmd_i.accept) begin
      rd_addr = '0;
    end else if (cmd_i.check) begin
      rd_addr = j_start;
    end else begin
      rd_addr = j_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= req_i.stamp;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    count_d       = count_q;
    prev_idx_d    = prev_idx_q;
    prev_hit_d    = prev_hit_q;
    stamp_d       = stamp_q;
    j_d           = j_q;
    last_d        = last_q;
    res_matched_d = res_matched_q;
    res_idx_d     = res_idx_q;
    res_dist_d    = res_dist_q;
    res_full_d    = res_full_q;
    out_matched_d = out_matched_q;
    out_idx_d     = out_idx_q;
    out_far_d     = out_far_q;
    out_full_d    = out_full_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;

    if (cmd_i.accept) begin
      stamp_d       = req_i.stamp;
      res_matched_d = 1'b0;
      res_idx_d     = '0;
      res_dist_d    = '0;
      res_full_d    = 1'b0;
      case (req_i.opcode)
        ntm_pkg::OP_APPEND: begin
          if (count_q < DEPTH_C) begin
            count_d = count_q + CW'(1);
          end else begin
            res_full_d = 1'b1;
          end
        end
        ntm_pkg::OP_QUERY: begin
          if (count_q == '0) begin
            prev_hit_d = 1'b0;
            prev_idx_d = '0;
          end
        end
        ntm_pkg::OP_CLEAR: begin
          count_d    = '0;
          prev_hit_d = 1'b0;
          prev_idx_d = '0;
        end
        default: ;
      endcase
    end

    if (cmd_i.check) begin
      if (sts_o.below_first) begin
        prev_hit_d = 1'b0;
        prev_idx_d = '0;
      end else begin
        j_d    = j_start;
        last_d = '1;
      end
    end

    if (cmd_i.walk) begin
      if (sts_o.grow) begin
        res_matched_d = 1'b1;
        res_idx_d     = j_q - AW'(1);
        res_dist_d    = last_q;
        prev_hit_d    = 1'b1;
        prev_idx_d    = j_q - AW'(1);
      end else if (sts_o.at_end) begin
        res_matched_d = 1'b1;
        res_idx_d     = j_q;
        res_dist_d    = cur_dist;
        prev_hit_d    = 1'b1;
        prev_idx_d    = j_q;
      end else begin
        last_d = cur_dist;
        j_d    = j_q + AW'(1);
      end
    end

    if (cmd_i.load) begin
      out_valid_d   = 1'b1;
      out_matched_d = res_matched_q;
      out_idx_d     = ntm_pkg::IDX_W'(res_idx_q);
      out_far_d     = res_matched_q && (res_dist_q > SW'(diff_limit_q));
      out_full_d    = res_full_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      prev_idx_q   <= '0;
      prev_hit_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      diff_limit_q <= ntm_pkg::DIFF_LIMIT_RESET;
    end else begin
      count_q     <= count_d;
      prev_idx_q  <= prev_idx_d;
      prev_hit_q  <= prev_hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        diff_limit_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q       <= stamp_d;
    j_q           <= j_d;
    last_q        <= last_d;
    res_matched_q <= res_matched_d;
    res_idx_q     <= res_idx_d;
    res_dist_q    <= res_dist_d;
    res_full_q    <= res_full_d;
    out_matched_q <= out_matched_d;
    out_idx_q     <= out_idx_d;
    out_far_q     <= out_far_d;
    out_full_q    <= out_full_d;
  end

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (count_q < DEPTH_C))
    else $error("append written beyond the reference store");

  a_walk_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (CW'(j_q) < count_q))
    else $error("walk reads past the end of the reference list");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || rsp_o.ready))
    else $error("result overwrites an item still waiting at the output");

  a_hit_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && res_matched_q) |-> (CW'(res_idx_q) < count_q))
    else $error("matched index outside the reference list");

endmodule

[src/nearest_timestamp_matcher_top.sv]
// ----------------------------------------------------------------------------
// nearest_timestamp_matcher_top
// Sequence, accepting edge to result valid: append, clear, no-op and a query
//   on an empty list go from IDLE to DONE; a query before the first entry also
//   passes CHECK; others pass CHECK, then WALK (one stamp memory read per cycle).
// Throughput: one item at work at a time; the next item is accepted the cycle
//   after the result loads, later while a finished item still waits in the
//   output register.
// Reset: list count, match history and output valid clear; the distance limit
//   returns to 10000000. The stamp memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module nearest_timestamp_matcher_top #(
  parameter int REF_DEPTH = ntm_pkg::REF_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ntm_req_if.sink   req_i,
  ntm_rsp_if.source rsp_o,
  ntm_cfg_if.sink   cfg_i
);

  // Command and status between the sequencer and the datapath. The
  // sequencer walks IDLE -> (CHECK -> (WALK ->)) DONE -> IDLE; the datapath
  // holds the reference store and all item state.
  ntm_pkg::cmd_t cmd;
  ntm_pkg::sts_t sts;

  // Sequencer: accept one item in IDLE, check entry 0 for queries, advance
  // through the list while the distance does not grow, then hold in DONE
  // until the output register is free.
  ntm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: stamp memory with registered read, walk index and best
  // distance, a result register, and an output register that keeps a
  // finished item while the next one is accepted and worked on.
  ntm_datapath #(
    .REF_DEPTH (REF_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
